FILE: rtl/acpu_pkg.sv
// ----------------------------------------------------------------------------
// acpu_pkg: shared types and constants of the accumulator CPU core
// Addressing modes, status codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package acpu_pkg;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_Y = 2'd1;

    localparam logic [15:0] PC_RESET = 16'hFFFC;

    // instruction groups (opcode bits 7:5)
    localparam logic [2:0] GRP_AND = 3'd1;
    localparam logic [2:0] GRP_ADC = 3'd3;
    localparam logic [2:0] GRP_LDA = 3'd5;

    localparam logic [1:0] CC_ALU = 2'd1;

    typedef enum logic [1:0] {
        ST_WRITE = 2'd0,
        ST_EXEC  = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    // addressing mode (opcode bits 4:2)
    typedef enum logic [2:0] {
        M_INDX = 3'd0,
        M_ZP   = 3'd1,
        M_IMM  = 3'd2,
        M_ABS  = 3'd3,
        M_INDY = 3'd4,
        M_ZPX  = 3'd5,
        M_ABSY = 3'd6,
        M_ABSX = 3'd7
    } t_mode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DEC,
        S_OP1,
        S_OP2,
        S_PTR_LO,
        S_PTR_HI,
        S_PTR_FIN,
        S_READ,
        S_EXEC,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        EA_KEEP,
        EA_BYTE,
        EA_WORD,
        EA_NEXT
    } t_ea_op;

    typedef enum logic [1:0] {
        IDX_NONE,
        IDX_X,
        IDX_Y
    } t_idx;

    typedef struct packed {
        logic   rd_pc;
        logic   rd_ea;
        logic   mem_wr;
        logic   op_load;
        logic   lo_load;
        t_ea_op ea_op;
        t_idx   idx_sel;
        logic   exec;
        logic   out_load;
        logic   clr_step;
    } t_dp_cmd;

    typedef struct packed {
        logic  clr_done;
        logic  dec_valid;
        t_mode mode;
        logic  out_full;
    } t_dp_status;

    function automatic logic f_dec_valid(input logic [7:0] op);
        logic [2:0] grp;
        grp = op[7:5];
        return (op[1:0] == CC_ALU) &&
               (grp == GRP_AND || grp == GRP_ADC || grp == GRP_LDA);
    endfunction

    function automatic logic [2:0] f_cycles(input t_mode mode);
        logic [2:0] c;
        unique case (mode)
            M_IMM:                c = 3'd2;
            M_ZP:                 c = 3'd3;
            M_ZPX, M_ABS:         c = 3'd4;
            M_ABSX, M_ABSY:       c = 3'd5;
            M_INDX, M_INDY:       c = 3'd6;
            default:              c = 3'd6;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/accumulator_cpu_lda_adc_and_top.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_lda_adc_and_top: 8-bit accumulator core, LDA/ADC/AND subset
// A memory write is accepted and its word loaded into the output register; an
// instruction is fetched and decoded (an unknown opcode ends there), then its
// address is built as its mode needs and its operand read, at most one memory port access per step.
// Items are taken one at a time, the next in the cycle after the result loads.
// Reset: after reset the byte memory is cleared for MEM_SIZE cycles before the
// first item is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module accumulator_cpu_lda_adc_and_top
    import acpu_pkg::*;
#(
    parameter int MEM_SIZE = 65536
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tdata: mem_address[15:0], mem_data[23:16]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: operation[0]
    input  logic                  i_s_axis_tuser,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: accumulator[7:0], carry_flag[8], zero_flag[9], negative_flag[10],
    //        overflow_flag[11], program_counter[27:12], opcode_seen[35:28],
    //        cycles_used[38:36], zero pad[39]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]            o_m_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]            i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    acpu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_op    (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    acpu_dpath #(
        .MEM_SIZE (MEM_SIZE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_addr   (i_s_axis_tdata[15:0]),
        .i_in_data   (i_s_axis_tdata[23:16]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );

    // one item in flight: no second word taken right after an accepted one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken twice in a row");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser != 2'd3))
        else $error("undefined status code");

    a_error_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == ST_ERROR) |->
            (o_m_axis_tdata[38:36] == 3'd1))
        else $error("unknown opcode must cost one cycle");

    a_write_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == ST_WRITE) |->
            (o_m_axis_tdata[38:28] == 11'd0))
        else $error("memory write reports opcode or cycles");

endmodule

FILE: rtl/acpu_ctrl.sv
// ----------------------------------------------------------------------------
// acpu_ctrl: instruction sequencer
// Walks each instruction through fetch, address build, operand read and execute,
// at most one memory access per state, and runs the memory clear after reset.
// ----------------------------------------------------------------------------
module acpu_ctrl
    import acpu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_op,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op) begin
                        o_cmd.rd_pc = 1'b1;
                        n_state     = S_DEC;
                    end else begin
                        o_cmd.mem_wr = 1'b1;
                        n_state      = S_DONE;
                    end
                end
            end
            S_DEC: begin
                o_cmd.op_load = 1'b1;
                if (i_status.dec_valid) begin
                    o_cmd.rd_pc = 1'b1;
                    n_state     = S_OP1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_OP1: begin
                unique case (i_status.mode)
                    M_IMM: begin
                        o_cmd.exec = 1'b1;
                        n_state    = S_DONE;
                    end
                    M_ABS, M_ABSX, M_ABSY: begin
                        o_cmd.lo_load = 1'b1;
                        o_cmd.rd_pc   = 1'b1;
                        n_state       = S_OP2;
                    end
                    M_ZP: begin
                        o_cmd.ea_op = EA_BYTE;
                        n_state     = S_READ;
                    end
                    M_ZPX: begin
                        o_cmd.ea_op   = EA_BYTE;
                        o_cmd.idx_sel = IDX_X;
                        n_state       = S_READ;
                    end
                    M_INDX: begin
                        o_cmd.ea_op   = EA_BYTE;
                        o_cmd.idx_sel = IDX_X;
                        n_state       = S_PTR_LO;
                    end
                    M_INDY: begin
                        o_cmd.ea_op = EA_BYTE;
                        n_state     = S_PTR_LO;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_OP2: begin
                o_cmd.ea_op = EA_WORD;
                if (i_status.mode == M_ABSX) begin
                    o_cmd.idx_sel = IDX_X;
                end else if (i_status.mode == M_ABSY) begin
                    o_cmd.idx_sel = IDX_Y;
                end
                n_state = S_READ;
            end
            S_PTR_LO: begin
                // read pointer low byte, step to the high byte within page zero
                o_cmd.rd_ea = 1'b1;
                o_cmd.ea_op = EA_NEXT;
                n_state     = S_PTR_HI;
            end
            S_PTR_HI: begin
                o_cmd.rd_ea   = 1'b1;
                o_cmd.lo_load = 1'b1;
                n_state       = S_PTR_FIN;
            end
            S_PTR_FIN: begin
                o_cmd.ea_op = EA_WORD;
                if (i_status.mode == M_INDY) begin
                    o_cmd.idx_sel = IDX_Y;
                end
                n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd_ea = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!i_status.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/acpu_dpath.sv
// ----------------------------------------------------------------------------
// acpu_dpath: registers, byte memory, address build and ALU
// Holds A, PC, flags, X and Y, the effective address, the byte memory with one
// write port and a registered read port, and the output word register.
// ----------------------------------------------------------------------------
module acpu_dpath
    import acpu_pkg::*;
#(
    parameter int MEM_SIZE = 65536
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]            i_cfg_data,
    input  logic [15:0]           i_in_addr,
    input  logic [7:0]            i_in_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic [1:0]            o_out_user
);

    localparam int AW = $clog2(MEM_SIZE);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_SIZE - 1);

    // reduce a 16-bit address modulo the memory size; quotient is below eight
    function automatic logic [AW-1:0] f_mod(input logic [15:0] a);
        logic [19:0] v;
        v = {4'd0, a};
        for (int k = 1; k < 8; k++) begin
            if ({4'd0, a} >= 20'(k * MEM_SIZE)) begin
                v = {4'd0, a} - 20'(k * MEM_SIZE);
            end
        end
        return v[AW-1:0];
    endfunction

    logic [7:0]  mem [MEM_SIZE];
    logic [7:0]  r_rdata;

    logic [7:0]  r_acc;
    logic        r_c;
    logic        r_z;
    logic        r_n;
    logic        r_v;
    logic [15:0] r_pc;
    logic [7:0]  r_x;
    logic [7:0]  r_y;
    logic [7:0]  r_op;
    logic [2:0]  r_cyc;
    t_status     r_st;
    logic [7:0]  r_lo;
    logic [15:0] r_ea;
    logic [AW-1:0] r_clr_addr;

    logic                  r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    logic [1:0]            r_ouser;

    logic [7:0]  n_acc;
    logic        n_c;
    logic        n_v;
    logic [8:0]  sum;
    logic [7:0]  idx;
    logic [15:0] n_ea;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]  wr_data;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic        dec_ok;

    // ---------------- memory ----------------
    assign wr_en   = i_cmd.clr_step | i_cmd.mem_wr;
    assign wr_addr = i_cmd.clr_step ? r_clr_addr : f_mod(i_in_addr);
    assign wr_data = i_cmd.clr_step ? 8'd0 : i_in_data;
    assign rd_en   = i_cmd.rd_pc | i_cmd.rd_ea;
    assign rd_addr = f_mod(i_cmd.rd_pc ? r_pc : r_ea);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // ---------------- address build ----------------
    always_comb begin
        unique case (i_cmd.idx_sel)
            IDX_X:   idx = r_x;
            IDX_Y:   idx = r_y;
            default: idx = 8'd0;
        endcase
        unique case (i_cmd.ea_op)
            EA_BYTE: n_ea = {8'd0, r_rdata + idx};
            EA_WORD: n_ea = {r_rdata, r_lo} + {8'd0, idx};
            EA_NEXT: n_ea = {8'd0, r_ea[7:0] + 8'd1};
            default: n_ea = r_ea;
        endcase
    end

    // ---------------- ALU ----------------
    always_comb begin
        sum   = {1'b0, r_acc} + {1'b0, r_rdata} + {8'd0, r_c};
        n_acc = r_acc;
        n_c   = r_c;
        n_v   = r_v;
        priority if (r_op[7:5] == GRP_LDA) begin
            n_acc = r_rdata;
        end else if (r_op[7:5] == GRP_AND) begin
            n_acc = r_acc & r_rdata;
        end else begin
            n_acc = sum[7:0];
            n_c   = sum[8];
            n_v   = (r_acc[7] ^ sum[7]) & (r_rdata[7] ^ sum[7]);
        end
    end

    assign dec_ok = f_dec_valid(r_rdata);

    // ---------------- architectural state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 8'd0;
            r_c   <= 1'b0;
            r_z   <= 1'b0;
            r_n   <= 1'b0;
            r_v   <= 1'b0;
            r_pc  <= PC_RESET;
            r_x   <= 8'd0;
            r_y   <= 8'd0;
        end else begin
            if (i_cmd.rd_pc) begin
                r_pc <= r_pc + 16'd1;
            end
            if (i_cmd.exec) begin
                r_acc <= n_acc;
                r_c   <= n_c;
                r_v   <= n_v;
                r_z   <= (n_acc == 8'd0);
                r_n   <= n_acc[7];
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_IDX_X) begin
                    r_x <= i_cfg_data;
                end else if (i_cfg_index == CFG_IDX_Y) begin
                    r_y <= i_cfg_data;
                end
            end
        end
    end

    // item bookkeeping and address registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_op  <= 8'd0;
            r_cyc <= 3'd0;
            r_st  <= ST_WRITE;
        end else if (i_cmd.op_load) begin
            r_op  <= r_rdata;
            r_cyc <= dec_ok ? f_cycles(t_mode'(r_rdata[4:2])) : 3'd1;
            r_st  <= dec_ok ? ST_EXEC : ST_ERROR;
        end
        if (i_cmd.lo_load) begin
            r_lo <= r_rdata;
        end
        r_ea <= n_ea;
    end

    // ---------------- output word register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odata <= {1'b0, r_cyc, r_op, r_pc, r_v, r_n, r_z, r_c, r_acc};
            r_ouser <= r_st;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign o_out_user  = r_ouser;

    assign o_status.clr_done  = (r_clr_addr == CLR_LAST);
    assign o_status.dec_valid = dec_ok;
    assign o_status.mode      = t_mode'(r_op[4:2]);
    assign o_status.out_full  = r_ovalid & ~i_out_ready;

endmodule

FILE: tb/accumulator_cpu_lda_adc_and_top_test.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_lda_adc_and_top_test: self-checking bench for the LDA/ADC/AND core
// A shadow core tracks memory, accumulator, flags and PC for every accepted
// input word and predicts the output word. Small programs are written byte by
// byte at the predicted PC and then run, under several X/Y index settings,
// with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module accumulator_cpu_lda_adc_and_top_test
    import acpu_pkg::*;
();

    localparam int CLK_PERIOD       = 12;
    localparam int MEM_BYTES        = 65536;
    localparam int PHASES           = 6;
    localparam int PHASE_ITEMS      = 280;
    localparam int LONG_HOLD_AT     = 700;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 20;
    localparam int TIMEOUT_CYCLES   = 800000;
    localparam int MAX_REPORTS      = 100;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EXEC  = 1'b1;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

    typedef struct {
        t_status     status;
        logic [7:0]  acc;
        logic        c;
        logic        z;
        logic        n;
        logic        v;
        logic [15:0] pc;
        logic [7:0]  opcode;
        logic [2:0]  cycles;
    } t_cpu_word;

    class acpu_shadow;
        logic [7:0]  mem [MEM_BYTES];
        logic [7:0]  acc;
        logic [15:0] pc;
        logic        c, z, n, v;
        logic [7:0]  idx_x, idx_y;
        int          steps;
        t_cpu_word   pending[$];
        int          errors, n_items, n_writes, n_exec, n_unknown, n_checked;

        function new();
            foreach (mem[i]) mem[i] = 8'h00;
            acc = 8'h00;
            pc = PC_RESET;
            {c, z, n, v} = 4'b0000;
            idx_x = 8'h00;
            idx_y = 8'h00;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            if (idx == CFG_IDX_X)
                idx_x = val;
            else if (idx == CFG_IDX_Y)
                idx_y = val;
        endfunction

        function logic [7:0] peek(logic [15:0] a);
            steps++;
            return mem[a % MEM_BYTES];
        endfunction

        function logic [7:0] fetch();
            logic [7:0] b;
            b = peek(pc);
            pc = pc + 16'd1;
            return b;
        endfunction

        function logic [15:0] fetch_word();
            logic [7:0] lo;
            lo = fetch();
            return {fetch(), lo};
        endfunction

        // pointer halves both stay in page zero
        function logic [15:0] zp_word(logic [7:0] p);
            logic [7:0] lo, p_next;
            p_next = p + 8'd1;
            lo = peek({8'h00, p});
            return {peek({8'h00, p_next}), lo};
        endfunction

        function void accept_item(logic op, logic [15:0] addr, logic [7:0] data);
            t_cpu_word   r;
            logic [7:0]  opc, operand, zp;
            logic [15:0] ea;
            logic [8:0]  sum;
            logic [2:0]  grp;
            t_mode       mode;
            steps = 0;
            opc = 8'h00;
            r.status = ST_WRITE;
            n_items++;
            if (op == OP_WRITE) begin
                mem[addr % MEM_BYTES] = data;
                n_writes++;
            end else begin
                opc = fetch();
                grp = opc[7:5];
                mode = t_mode'(opc[4:2]);
                if (opc[1:0] != CC_ALU || !(grp inside {GRP_AND, GRP_ADC, GRP_LDA})) begin
                    r.status = ST_ERROR;
                    n_unknown++;
                end else begin
                    ea = 16'h0000;
                    case (mode)
                        M_INDX: begin
                            zp = fetch();
                            zp = zp + idx_x;
                            steps++;
                            ea = zp_word(zp);
                        end
                        M_ZP:   ea = {8'h00, fetch()};
                        M_ZPX: begin
                            zp = fetch();
                            zp = zp + idx_x;
                            steps++;
                            ea = {8'h00, zp};
                        end
                        M_ABS:  ea = fetch_word();
                        M_ABSX: begin
                            ea = fetch_word() + idx_x;
                            steps++;
                        end
                        M_ABSY: begin
                            ea = fetch_word() + idx_y;
                            steps++;
                        end
                        M_INDY: begin
                            ea = zp_word(fetch()) + idx_y;
                            steps++;
                        end
                        default: ;
                    endcase
                    operand = (mode == M_IMM) ? fetch() : peek(ea);
                    case (grp)
                        GRP_LDA: acc = operand;
                        GRP_AND: acc = acc & operand;
                        default: begin
                            sum = acc + operand + c;
                            c = sum[8];
                            v = (acc[7] ^ sum[7]) & (operand[7] ^ sum[7]);
                            acc = sum[7:0];
                        end
                    endcase
                    z = (acc == 8'h00);
                    n = acc[7];
                    r.status = ST_EXEC;
                    n_exec++;
                end
            end
            r.acc = acc;
            r.c = c;
            r.z = z;
            r.n = n;
            r.v = v;
            r.pc = pc;
            r.opcode = opc;
            r.cycles = steps[2:0];
            pending.push_back(r);
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [1:0] user, logic [OUT_DATA_W-1:0] word);
            t_cpu_word e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: output word with nothing pending: expected none, got status %0h data %h",
                         $time, user, word);
                return;
            end
            e = pending.pop_front();
            compare("status", e.status, user);
            compare("accumulator", e.acc, word[7:0]);
            compare("carry_flag", e.c, word[8]);
            compare("zero_flag", e.z, word[9]);
            compare("negative_flag", e.n, word[10]);
            compare("overflow_flag", e.v, word[11]);
            compare("program_counter", e.pc, word[27:12]);
            compare("opcode_seen", e.opcode, word[35:28]);
            compare("cycles_used", e.cycles, word[38:36]);
            n_checked++;
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [7:0]            cfg_data;

    acpu_shadow model = new();

    accumulator_cpu_lda_adc_and_top #(
        .MEM_SIZE(MEM_BYTES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("[accumulator_cpu_lda_adc_and_top] ERROR");
        $finish;
    end

    function automatic logic [7:0] opcode_of(logic [2:0] grp, t_mode mode);
        return {grp, mode, CC_ALU};
    endfunction

    // lean on the sign and carry boundaries half of the time
    function automatic logic [7:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'h7F;
            2:       return 8'h80;
            3:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // called and returns just after a falling edge; tvalid stays high on return
    task automatic send_word(input logic op, input logic [15:0] addr, input logic [7:0] data);
        int gap;
        gap = (((model.n_items / 64) % 4) == 1) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {data, addr};
        do @(posedge i_clk); while (!s_tready);
        model.accept_item(op, addr, data);
        @(negedge i_clk);
    endtask

    task automatic poke(input logic [15:0] addr, input logic [7:0] data);
        send_word(OP_WRITE, addr, data);
    endtask

    task automatic step_cpu();
        send_word(OP_EXEC, 16'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (model.pending.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge i_clk); while (!cfg_ready);
        model.note_config(idx, val);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // lay one instruction, its pointer and its operand into memory, then run it
    task automatic random_program();
        logic [7:0]  opc, zpa, zp_next, p, val;
        logic [15:0] pc, base, ptr, ea;
        logic [2:0]  grp;
        t_mode       mode;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            // noise word: any operation at any address
            send_word(1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom));
            return;
        end
        pc = model.pc;
        case ($urandom_range(0, 2))
            0:       grp = GRP_AND;
            1:       grp = GRP_ADC;
            default: grp = GRP_LDA;
        endcase
        opc = opcode_of(grp, t_mode'($urandom_range(0, 7)));
        if (pick < 12)
            opc = 8'($urandom);
        grp = opc[7:5];
        mode = t_mode'(opc[4:2]);
        poke(pc, opc);
        if (opc[1:0] == CC_ALU && grp inside {GRP_AND, GRP_ADC, GRP_LDA}) begin
            val = pick_value();
            zpa = 8'($urandom);
            zp_next = zpa + 8'd1;
            base = 16'($urandom);
            ptr = 16'($urandom);
            ea = {8'h00, zpa};
            case (mode)
                M_IMM:  poke(pc + 16'd1, val);
                M_ZP:   poke(pc + 16'd1, zpa);
                M_ZPX: begin
                    poke(pc + 16'd1, zpa);
                    p = zpa + model.idx_x;
                    ea = {8'h00, p};
                end
                M_ABS, M_ABSX, M_ABSY: begin
                    poke(pc + 16'd1, base[7:0]);
                    poke(pc + 16'd2, base[15:8]);
                    ea = base;
                    if (mode == M_ABSX)
                        ea = base + model.idx_x;
                    else if (mode == M_ABSY)
                        ea = base + model.idx_y;
                end
                M_INDX: begin
                    poke(pc + 16'd1, zpa);
                    p = zpa + model.idx_x;
                    poke({8'h00, p}, ptr[7:0]);
                    p = p + 8'd1;
                    poke({8'h00, p}, ptr[15:8]);
                    ea = ptr;
                end
                default: begin
                    poke(pc + 16'd1, zpa);
                    poke({8'h00, zpa}, ptr[7:0]);
                    poke({8'h00, zp_next}, ptr[15:8]);
                    ea = ptr + model.idx_y;
                end
            endcase
            // now and then leave the operand as whatever memory holds
            if (mode != M_IMM && pick >= 18)
                poke(ea, val);
        end
        step_cpu();
    endtask

    // result side: random stalls, one long hold-off, quiet stretches
    initial begin : result_side
        int gap;
        int got;
        m_tready = 1'b0;
        got = 0;
        @(negedge i_clk);
        forever begin
            gap = (((got / 64) % 4) == 1) ? 0 : $urandom_range(0, 15);
            if (got == LONG_HOLD_AT)
                gap = LONG_HOLD_CYCLES;
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready = 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            model.check_result(m_tuser, m_tdata);
            got++;
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        logic [7:0] x_val, y_val;
        int         stop_at;
        bit         paused;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = OP_WRITE;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IDX_X;
        cfg_data = 8'h00;
        paused = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: widest indexes so every wrap case shows up
        write_reg(CFG_IDX_X, 8'hFF);
        write_reg(CFG_IDX_Y, 8'hFF);
        write_reg(CFG_IDX_SPARE2, 8'h5A);
        write_reg(CFG_IDX_SPARE3, 8'hA5);
        // cleared memory at the reset PC holds an unknown opcode
        step_cpu();
        poke(16'hFFFD, opcode_of(GRP_LDA, M_IMM));
        poke(16'hFFFE, 8'h80);
        step_cpu();
        // ADC $FFFF,X: operand bytes wrap the PC, sum wraps to $00FE
        poke(16'hFFFF, opcode_of(GRP_ADC, M_ABSX));
        poke(16'h0000, 8'hFF);
        poke(16'h0001, 8'hFF);
        poke(16'h00FE, 8'h80);
        step_cpu();
        // ADC ($00,X): pointer low at $FF, high at $00
        poke(16'h0002, opcode_of(GRP_ADC, M_INDX));
        poke(16'h0003, 8'h00);
        poke(16'h00FF, 8'h34);
        poke(16'hFF34, 8'h7F);
        step_cpu();
        // LDA ($FF),Y: pointer high wraps to $00, pointer plus Y wraps to $0033
        poke(16'h0004, opcode_of(GRP_LDA, M_INDY));
        poke(16'h0005, 8'hFF);
        poke(16'h0033, 8'hC3);
        step_cpu();
        // AND $80,X stays in page zero
        poke(16'h0006, opcode_of(GRP_AND, M_ZPX));
        poke(16'h0007, 8'h80);
        poke(16'h007F, 8'hFF);
        step_cpu();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       {x_val, y_val} = {8'h00, 8'h00};
                1:       {x_val, y_val} = {8'hFF, 8'hFF};
                2:       {x_val, y_val} = {8'h01, 8'h80};
                4:       {x_val, y_val} = {8'h80, 8'h7F};
                default: {x_val, y_val} = {8'($urandom), 8'($urandom)};
            endcase
            wait_drained();
            repeat (4) @(negedge i_clk);
            write_reg(CFG_IDX_X, x_val);
            write_reg(CFG_IDX_Y, y_val);
            stop_at = model.n_items + PHASE_ITEMS;
            while (model.n_items < stop_at) begin
                // hold the input until the core has caught up
                if (ph == 2 && !paused && model.n_items >= stop_at - PHASE_ITEMS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                random_program();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d byte writes, %0d executed and %0d unknown opcodes", model.n_writes,
                 model.n_exec, model.n_unknown);
        $display("over %0d index settings; %0d output words checked, %0d mismatches",
                 PHASES + 1, model.n_checked, model.errors);
        if (model.errors == 0 && model.pending.size() == 0)
            $display("[accumulator_cpu_lda_adc_and_top] OK");
        else
            $display("[accumulator_cpu_lda_adc_and_top] ERROR");
        $finish;
    end

endmodule
